>>> src/vctf_pkg.sv
// vctf_pkg: shared types, format codes and reciprocal constants for the
// vertex component to float converter. No dependencies.
package vctf_pkg;

    typedef enum logic [2:0] {
        FMT_FLOAT = 3'd0,
        FMT_S8    = 3'd1,
        FMT_U8    = 3'd2,
        FMT_S16   = 3'd3,
        FMT_U16   = 3'd4,
        FMT_S32   = 3'd5,
        FMT_U32   = 3'd6,
        FMT_NONE  = 3'd7
    } t_fmt;

    localparam logic CFG_FORMAT    = 1'b0;
    localparam logic CFG_NORMALIZE = 1'b1;

    localparam logic [23:0] MAN_ONE = 24'h800000;

    // single-precision scale factor: mantissa with hidden bit, unbiased exponent
    typedef struct packed {
        logic [23:0]       man;
        logic signed [7:0] exp;
    } t_recip;

    // converted integer handed from the convert stage to the scale stage
    typedef struct packed {
        logic        valid;
        logic        scale;
        logic        sign;
        logic [7:0]  exp;
        logic [23:0] man;
        t_recip      recip;
        logic [31:0] bits;
    } t_conv;

    // nearest single to -1/min (negative) or 1/max (positive)
    function automatic t_recip recip_lookup(input t_fmt fmt, input logic neg);
        t_recip r;
        r.man = MAN_ONE;
        r.exp = 8'sd0;
        unique case (fmt)
            FMT_S8: begin
                r.man = neg ? MAN_ONE : 24'h810204;
                r.exp = -8'sd7;
            end
            FMT_U8: begin
                r.man = 24'h808081;
                r.exp = -8'sd8;
            end
            FMT_S16: begin
                r.man = neg ? MAN_ONE : 24'h800100;
                r.exp = -8'sd15;
            end
            FMT_U16: begin
                r.man = 24'h800080;
                r.exp = -8'sd16;
            end
            FMT_S32: begin
                r.man = MAN_ONE;
                r.exp = -8'sd31;
            end
            FMT_U32: begin
                r.man = MAN_ONE;
                r.exp = -8'sd32;
            end
            default: begin
                r.man = MAN_ONE;
                r.exp = 8'sd0;
            end
        endcase
        return r;
    endfunction

endpackage

>>> src/vertex_component_to_float.sv
// vertex_component_to_float: top level with input and configuration registers.
// Instantiates vctf_convert and vctf_scale; uses vctf_pkg.
//
// One component word is taken in every cycle (busy is always low) and its
// single-precision result appears on o_value_bits with o_result_valid once it
// has passed the input register, the integer-to-float convert stage, and the
// multiply-and-round stage that applies the normalization constant. Results
// come out in order, one strobe per transaction, and must be taken as they come.
// Configuration (index 0 format, index 1 normalize) is to be written by the user only while idle; not enforced.
module vertex_component_to_float
    import vctf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_raw_bits,
    output logic        o_result_valid,
    output logic [31:0] o_value_bits,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_data
);

    logic        r_in_valid;
    logic [31:0] r_raw;
    t_fmt        r_fmt;
    logic        r_norm;
    t_conv       conv;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_fmt      <= FMT_FLOAT;
            r_norm     <= 1'b0;
        end else begin
            r_in_valid <= start & ~busy;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_FORMAT:    r_fmt  <= t_fmt'(i_cfg_data);
                    CFG_NORMALIZE: r_norm <= i_cfg_data[0];
                    default:       r_norm <= r_norm;
                endcase
            end
        end
        r_raw <= i_raw_bits;
    end

    vctf_convert u_convert (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_raw   (r_raw),
        .i_fmt   (r_fmt),
        .i_norm  (r_norm),
        .o_conv  (conv)
    );

    vctf_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_conv  (conv),
        .o_valid (o_result_valid),
        .o_bits  (o_value_bits)
    );

endmodule

>>> src/vctf_convert.sv
// vctf_convert: decodes the component word by format and converts integers
// to single precision (round to nearest even). Registered output. Uses vctf_pkg.
module vctf_convert
    import vctf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_raw,
    input  t_fmt        i_fmt,
    input  logic        i_norm,
    output t_conv       o_conv
);

    logic [31:0] sx;
    logic        is_int;
    logic        neg;
    logic [31:0] mag;
    logic [4:0]  p;
    logic [31:0] norm;
    logic        round_up;
    logic [24:0] q;
    logic [7:0]  be;
    logic [23:0] man;
    t_conv       n_conv;
    t_conv       r_conv;

    always_comb begin
        sx     = 32'd0;
        is_int = 1'b1;
        neg    = 1'b0;
        unique case (i_fmt)
            FMT_S8: begin
                sx  = {{24{i_raw[7]}}, i_raw[7:0]};
                neg = i_raw[7];
            end
            FMT_U8:  sx = {24'd0, i_raw[7:0]};
            FMT_S16: begin
                sx  = {{16{i_raw[15]}}, i_raw[15:0]};
                neg = i_raw[15];
            end
            FMT_U16: sx = {16'd0, i_raw[15:0]};
            FMT_S32: begin
                sx  = i_raw;
                neg = i_raw[31];
            end
            FMT_U32: sx = i_raw;
            default: is_int = 1'b0;
        endcase
        mag = neg ? (~sx + 32'd1) : sx;

        // leading one position
        p = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (mag[i]) begin
                p = 5'(i);
            end
        end
        norm     = mag << (5'd31 - p);
        round_up = norm[7] & (norm[8] | (|norm[6:0]));
        q        = {1'b0, norm[31:8]} + {24'd0, round_up};
        if (q[24]) begin
            man = MAN_ONE;
            be  = {3'd0, p} + 8'd128;
        end else begin
            man = q[23:0];
            be  = {3'd0, p} + 8'd127;
        end

        n_conv.valid = i_valid;
        n_conv.sign  = neg;
        n_conv.exp   = be;
        n_conv.man   = man;
        n_conv.recip = recip_lookup(i_fmt, neg);
        n_conv.scale = is_int & i_norm & (mag != 32'd0);
        if (i_fmt == FMT_FLOAT) begin
            // nan and infinity collapse to +0.0
            n_conv.bits = (i_raw[30:23] == 8'hFF) ? 32'd0 : i_raw;
        end else if (!is_int || mag == 32'd0) begin
            n_conv.bits = 32'd0;
        end else begin
            n_conv.bits = {neg, be, man[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv.valid <= 1'b0;
        end else begin
            r_conv.valid <= n_conv.valid;
        end
        r_conv.scale <= n_conv.scale;
        r_conv.sign  <= n_conv.sign;
        r_conv.exp   <= n_conv.exp;
        r_conv.man   <= n_conv.man;
        r_conv.recip <= n_conv.recip;
        r_conv.bits  <= n_conv.bits;
    end

    assign o_conv = r_conv;

endmodule

>>> src/vctf_scale.sv
// vctf_scale: multiplies a converted integer by its normalization constant,
// rounding to nearest even, and registers the result. Uses vctf_pkg.
module vctf_scale
    import vctf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_conv       i_conv,
    output logic        o_valid,
    output logic [31:0] o_bits
);

    logic [47:0] prod;
    logic        top;
    logic [23:0] keep;
    logic        rbit;
    logic        sticky;
    logic [24:0] q;
    logic [23:0] man;
    logic [9:0]  exp_s;
    logic [31:0] n_bits;
    logic        r_valid;
    logic [31:0] r_bits;

    always_comb begin
        prod = {24'd0, i_conv.man} * {24'd0, i_conv.recip.man};
        top  = prod[47];
        if (top) begin
            keep   = prod[47:24];
            rbit   = prod[23];
            sticky = |prod[22:0];
        end else begin
            keep   = prod[46:23];
            rbit   = prod[22];
            sticky = |prod[21:0];
        end
        q = {1'b0, keep} + {24'd0, rbit & (keep[0] | sticky)};
        man = q[24] ? MAN_ONE : q[23:0];
        exp_s = {2'd0, i_conv.exp} + {{2{i_conv.recip.exp[7]}}, i_conv.recip.exp}
              + {9'd0, top} + {9'd0, q[24]};
        n_bits = i_conv.scale ? {i_conv.sign, exp_s[7:0], man[22:0]} : i_conv.bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_conv.valid;
        end
        r_bits <= n_bits;
    end

    assign o_valid = r_valid;
    assign o_bits  = r_bits;

endmodule
